@@ rtl/core/cpid_pkg.sv @@
// Shared widths, register indexes, stage payload types and clamp helper for the PID core.
`default_nettype none

package cpid_pkg;

    // Field and datapath widths
    localparam int DATA_W  = 16;                 // feedback, setpoint, drive, integral
    localparam int GAIN_W  = 16;                 // signed Q8.8 gains
    localparam int LIM_W   = 15;                 // clamp magnitudes
    localparam int FRAC_W  = 8;                  // fraction bits of the gains
    localparam int ERR_W   = DATA_W + 1;         // setpoint - feedback
    localparam int DIFF_W  = ERR_W + 1;          // error - previous error
    localparam int PP_W    = GAIN_W + ERR_W;     // gain * error
    localparam int DP_W    = GAIN_W + DIFF_W;    // gain * error difference
    localparam int PT_W    = PP_W - FRAC_W;      // proportional term after shift
    localparam int SUM_W   = DP_W - FRAC_W;      // wide sums ahead of a clamp
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX          = 3'd5;

    // Input command codes
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         integral_limit;
        logic [LIM_W-1:0]         derivative_limit;
        logic [LIM_W-1:0]         out_max;
    } cpid_cfg_t;

    typedef struct packed {
        logic                     clear;
        logic signed [ERR_W-1:0]  error;
        logic signed [DIFF_W-1:0] diff;
    } cpid_err_t;

    typedef struct packed {
        logic                   clear;
        logic signed [PP_W-1:0] p_prod;
        logic signed [PP_W-1:0] i_prod;
        logic signed [DP_W-1:0] d_prod;
    } cpid_prod_t;

    typedef struct packed {
        logic signed [PT_W-1:0]   p_term;
        logic signed [DATA_W-1:0] i_term;
        logic signed [DATA_W-1:0] d_term;
    } cpid_term_t;

    // Symmetric clamp of a wide signed value to +-lim
    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SUM_W-1:0]  hi;
        logic signed [SUM_W-1:0]  lo;
        logic signed [DATA_W-1:0] r;
        hi = $signed(SUM_W'(lim));
        lo = -hi;
        if (v > hi)
        begin
            r = hi[DATA_W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cpid_if.sv @@
// Handshake interfaces for the PID core: input item, result item and configuration write.
`default_nettype none

interface cpid_item_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic signed [cpid_pkg::DATA_W-1:0]     feedback;
    logic signed [cpid_pkg::DATA_W-1:0]     setpoint;
    modport source (output valid, command, feedback, setpoint, input ready);
    modport sink   (input valid, command, feedback, setpoint, output ready);
endinterface

interface cpid_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cpid_pkg::DATA_W-1:0]     drive;
    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

interface cpid_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [cpid_pkg::CFG_IDX_W-1:0]         index;
    logic [cpid_pkg::DATA_W-1:0]            data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cpid_error.sv @@
// Input stage: register the error and its difference from the previous error.
`default_nettype none

module cpid_error (
    input  wire logic            clk,
    input  wire logic            rst_n,
    cpid_item_if.sink            item,
    output cpid_pkg::cpid_err_t  out_data,
    output logic                 out_valid,
    input  wire logic            out_ready
);
    import cpid_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    cpid_err_t               data_reg;
    cpid_err_t               data_next;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;
    logic                    load;
    logic signed [ERR_W-1:0] error;

    // Take an item whenever this stage is empty or drains this cycle
    assign item.ready = !valid_reg || out_ready;
    assign load       = item.valid && item.ready;

    // Form error and difference against the error history
    always_comb
    begin
        error           = ERR_W'(item.setpoint) - ERR_W'(item.feedback);
        data_next.clear = (item.command == CMD_CLEAR);
        data_next.error = error;
        data_next.diff  = DIFF_W'(error) - DIFF_W'(prev_err_reg);
        valid_next      = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        prev_err_next   = prev_err_reg;
        if (load)
        begin
            prev_err_next = data_next.clear ? '0 : error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            prev_err_reg <= prev_err_next;
        end
    end

    // Hold payload unless a new item loads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    a_clear_drops_history: assert property (@(posedge clk) disable iff (!rst_n)
        load && item.command == CMD_CLEAR |=> prev_err_reg == '0)
        else $error("error history not cleared by clear item");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cpid_gain.sv @@
// Multiplier stage: the three gain products, one registered multiply each.
`default_nettype none

module cpid_gain (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cpid_pkg::cpid_cfg_t  cfg,
    input  wire cpid_pkg::cpid_err_t  in_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output cpid_pkg::cpid_prod_t      out_data,
    output logic                      out_valid,
    input  wire logic                 out_ready
);
    import cpid_pkg::*;

    logic       valid_reg;
    cpid_prod_t data_reg;
    cpid_prod_t data_next;
    logic       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Multiply each gain by its operand
    always_comb
    begin
        data_next.clear  = in_data.clear;
        data_next.p_prod = PP_W'(cfg.gain_p) * PP_W'(in_data.error);
        data_next.i_prod = PP_W'(cfg.gain_i) * PP_W'(in_data.error);
        data_next.d_prod = DP_W'(cfg.gain_d) * DP_W'(in_data.diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/cpid_terms.sv @@
// Term stage: scale products, accumulate and clamp the integral, clamp the derivative.
`default_nettype none

module cpid_terms (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cpid_pkg::cpid_cfg_t  cfg,
    input  wire cpid_pkg::cpid_prod_t in_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output cpid_pkg::cpid_term_t      out_data,
    output logic                      out_valid,
    input  wire logic                 out_ready
);
    import cpid_pkg::*;

    logic                     valid_reg;
    logic signed [DATA_W-1:0] integral_reg;
    logic signed [DATA_W-1:0] integral_next;
    logic signed [PT_W-1:0]   p_term_reg;
    logic signed [PT_W-1:0]   p_term_next;
    logic signed [DATA_W-1:0] d_term_reg;
    logic signed [DATA_W-1:0] d_term_next;
    logic signed [SUM_W-1:0]  integral_sum;
    logic                     load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Drop the fraction bits (floor), then accumulate and clamp
    always_comb
    begin
        integral_sum = SUM_W'(integral_reg) + SUM_W'($signed(in_data.i_prod[PP_W-1:FRAC_W]));
        if (in_data.clear)
        begin
            integral_next = '0;
            p_term_next   = '0;
            d_term_next   = '0;
        end
        else
        begin
            integral_next = clamp_sym(integral_sum, cfg.integral_limit);
            p_term_next   = in_data.p_prod[PP_W-1:FRAC_W];
            d_term_next   = clamp_sym(in_data.d_prod[DP_W-1:FRAC_W], cfg.derivative_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            integral_reg <= '0;
        end
        else if (load)
        begin
            valid_reg    <= 1'b1;
            integral_reg <= integral_next;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_term_reg <= p_term_next;
            d_term_reg <= d_term_next;
        end
    end

    // Integral register doubles as the I term of the item held here
    assign out_valid       = valid_reg;
    assign out_data.p_term = p_term_reg;
    assign out_data.i_term = integral_reg;
    assign out_data.d_term = d_term_reg;

`ifndef NO_ASSERTIONS
    a_clear_zeroes_integral: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_data.clear |=> integral_reg == '0 && p_term_reg == '0)
        else $error("integral or P term not zeroed by clear item");

    a_d_term_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (d_term_reg <= $signed({1'b0, cfg.derivative_limit}))
                   && (d_term_reg >= -$signed({1'b0, cfg.derivative_limit})))
        else $error("D term outside its clamp");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cpid_drive.sv @@
// Output stage: sum the three terms, clamp to the drive limit and hold the result item.
`default_nettype none

module cpid_drive (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cpid_pkg::cpid_cfg_t  cfg,
    input  wire cpid_pkg::cpid_term_t in_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    cpid_result_if.source             res
);
    import cpid_pkg::*;

    logic                     valid_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic signed [DATA_W-1:0] drive_next;
    logic signed [SUM_W-1:0]  sum;
    logic                     load;

    assign in_ready = !valid_reg || res.ready;
    assign load     = in_valid && in_ready;

    // Add P, I and D, then clamp
    always_comb
    begin
        sum        = SUM_W'(in_data.p_term) + SUM_W'(in_data.i_term) + SUM_W'(in_data.d_term);
        drive_next = clamp_sym(sum, cfg.out_max);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign res.valid = valid_reg;
    assign res.drive = drive_reg;

`ifndef NO_ASSERTIONS
    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (drive_reg <= $signed({1'b0, cfg.out_max}))
                   && (drive_reg >= -$signed({1'b0, cfg.out_max})))
        else $error("drive outside the output clamp");
`endif

endmodule

`default_nettype wire

@@ rtl/core/clamped_pid_controller.sv @@
// A result item passes through the input, multiplier, term and output stage registers in order.
// Throughput: one item per cycle while the result side is ready; each of the four stage registers moves on
// when the stage after it is empty or draining, set by the result handshake.
// Integral and error history live in the term and input stages, one update per item.
// Reset (rst_n, async, active low): all gains and limits 0, integral and
// error history 0, pipeline empty. Configuration writes are taken every cycle.
`default_nettype none

module clamped_pid_controller (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cpid_item_if.sink       item_in,
    cpid_result_if.source   result_out,
    cpid_cfg_if.sink        cfg
);
    import cpid_pkg::*;

    cpid_cfg_t  cfg_reg;
    cpid_err_t  err_data;
    logic       err_valid;
    logic       err_ready;
    cpid_prod_t prod_data;
    logic       prod_valid;
    logic       prod_ready;
    cpid_term_t term_data;
    logic       term_valid;
    logic       term_ready;

    // Register file: write on handshake, ignore unknown indexes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GAIN_P:           cfg_reg.gain_p           <= $signed(cfg.data);
                REG_GAIN_I:           cfg_reg.gain_i           <= $signed(cfg.data);
                REG_GAIN_D:           cfg_reg.gain_d           <= $signed(cfg.data);
                REG_INTEGRAL_LIMIT:   cfg_reg.integral_limit   <= cfg.data[LIM_W-1:0];
                REG_DERIVATIVE_LIMIT: cfg_reg.derivative_limit <= cfg.data[LIM_W-1:0];
                REG_OUT_MAX:          cfg_reg.out_max          <= cfg.data[LIM_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    cpid_error u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_in),
        .out_data  (err_data),
        .out_valid (err_valid),
        .out_ready (err_ready)
    );

    cpid_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (err_data),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .out_data  (prod_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready)
    );

    cpid_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (prod_data),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .out_data  (term_data),
        .out_valid (term_valid),
        .out_ready (term_ready)
    );

    cpid_drive u_drive (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (term_data),
        .in_valid (term_valid),
        .in_ready (term_ready),
        .res      (result_out)
    );

endmodule

`default_nettype wire
